FILE: rtl/core/rectified_line_power_good_detector_top_defines.svh
// Assertion macros used by the checker of the power-good detector.
`ifndef RECTIFIED_LINE_POWER_GOOD_DETECTOR_TOP_DEFINES_SVH
`define RECTIFIED_LINE_POWER_GOOD_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RLPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpg: same-cycle property failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RLPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpg: next-cycle property failed");

`endif

FILE: rtl/core/rlpg_pkg.sv
// Types, constants and helper functions of the power-good detector.
package rlpg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int COEF_W   = 43;
    localparam int STATE_W  = 64;
    localparam int FRAC_W   = 40;
    localparam int THR_W    = 15;
    localparam int OPND_W   = 33;
    localparam int PROD_W   = COEF_W + OPND_W;
    localparam int ACC_W    = COEF_W + STATE_W;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COEF_W-1:0] B0_RESET  = 43'sd595484;
    localparam logic signed [COEF_W-1:0] B1_RESET  = 43'sd1190967;
    localparam logic signed [COEF_W-1:0] B2_RESET  = 43'sd595484;
    localparam logic signed [COEF_W-1:0] A1_RESET  = -43'sd2196733412361;
    localparam logic signed [COEF_W-1:0] A2_RESET  = 43'sd1097224166521;
    localparam logic [THR_W-1:0]         THR_RESET = 15'd320;

    localparam logic signed [STATE_W-1:0] S64_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] S64_MIN = {1'b1, {(STATE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0  = 3'd0,
        REG_B1  = 3'd1,
        REG_B2  = 3'd2,
        REG_A1  = 3'd3,
        REG_A2  = 3'd4,
        REG_THR = 3'd5
    } rlpg_reg_t;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2
    } rlpg_coef_t;

    typedef enum logic [1:0] {
        OPND_X,
        OPND_Y_LO,
        OPND_Y_HI
    } rlpg_opnd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B0,
        S_B1,
        S_B2,
        S_A1L,
        S_A1H,
        S_A2L,
        S_A2H,
        S_FB1,
        S_FB2,
        S_UPD2,
        S_OUT
    } rlpg_state_t;

    typedef struct packed {
        rlpg_coef_t coef_sel;
        rlpg_opnd_t opnd_sel;
        logic       load_in;
        logic       load_y;
        logic       load_t1;
        logic       load_t2;
        logic       acc_load;
        logic       acc_add;
        logic       fb_load;
        logic       upd_d1;
        logic       upd_d2;
        logic       res_load;
    } rlpg_cmd_t;

    // Saturates a 65-bit signed sum or difference to 64 bits.
    function automatic logic signed [STATE_W-1:0] sat65(input logic signed [STATE_W:0] v);
        logic signed [STATE_W-1:0] r;
        if (v[STATE_W] != v[STATE_W-1])
        begin
            r = v[STATE_W] ? S64_MIN : S64_MAX;
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    // Absolute value of a sample; the most negative code maps to the largest positive one.
    function automatic logic [MAG_W-1:0] abs_sat(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] n;
        logic [MAG_W-1:0]    r;
        n = -v;
        if (v == {1'b1, {(SAMPLE_W-1){1'b0}}})
        begin
            r = {MAG_W{1'b1}};
        end
        else if (v[SAMPLE_W-1])
        begin
            r = n[MAG_W-1:0];
        end
        else
        begin
            r = v[MAG_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/rlpg_in_if.sv
// Sample channel: valid/ready handshake with the three line voltages and the DC link.
interface rlpg_in_if;
    import rlpg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] volt_ab;
    logic signed [SAMPLE_W-1:0] volt_bc;
    logic signed [SAMPLE_W-1:0] volt_ca;
    logic signed [SAMPLE_W-1:0] volt_dc_link;

    modport source (output valid, output volt_ab, output volt_bc, output volt_ca,
                    output volt_dc_link, input ready);
    modport sink   (input valid, input volt_ab, input volt_bc, input volt_ca,
                    input volt_dc_link, output ready);
endinterface

FILE: rtl/core/rlpg_out_if.sv
// Result channel: valid/ready handshake with the power-good flag and the filtered level.
interface rlpg_out_if;
    import rlpg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       power_good;
    logic signed [SAMPLE_W-1:0] filtered_level;

    modport source (output valid, output power_good, output filtered_level, input ready);
    modport sink   (input valid, input power_good, input filtered_level, output ready);
endinterface

FILE: rtl/core/rlpg_ctrl.sv
// Sequencer that steps the shared multiplier and the filter update for one beat.
module rlpg_ctrl
    import rlpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output rlpg_cmd_t cmd
);

    rlpg_state_t state_reg;
    rlpg_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.coef_sel = COEF_B0;
        cmd.opnd_sel = OPND_X;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_B0;
                end
            end
            S_B0:
            begin
                state_next = S_B1;
            end
            S_B1:
            begin
                cmd.coef_sel = COEF_B1;
                cmd.load_y   = 1'b1;
                state_next   = S_B2;
            end
            S_B2:
            begin
                cmd.coef_sel = COEF_B2;
                cmd.load_t1  = 1'b1;
                state_next   = S_A1L;
            end
            S_A1L:
            begin
                cmd.coef_sel = COEF_A1;
                cmd.opnd_sel = OPND_Y_LO;
                cmd.load_t2  = 1'b1;
                state_next   = S_A1H;
            end
            S_A1H:
            begin
                cmd.coef_sel = COEF_A1;
                cmd.opnd_sel = OPND_Y_HI;
                cmd.acc_load = 1'b1;
                state_next   = S_A2L;
            end
            S_A2L:
            begin
                cmd.coef_sel = COEF_A2;
                cmd.opnd_sel = OPND_Y_LO;
                cmd.acc_add  = 1'b1;
                state_next   = S_A2H;
            end
            S_A2H:
            begin
                cmd.coef_sel = COEF_A2;
                cmd.opnd_sel = OPND_Y_HI;
                cmd.fb_load  = 1'b1;
                cmd.acc_load = 1'b1;
                state_next   = S_FB1;
            end
            S_FB1:
            begin
                cmd.upd_d1  = 1'b1;
                cmd.acc_add = 1'b1;
                state_next  = S_FB2;
            end
            S_FB2:
            begin
                cmd.fb_load = 1'b1;
                state_next  = S_UPD2;
            end
            S_UPD2:
            begin
                cmd.upd_d2 = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/rlpg_dp.sv
// Datapath: configuration registers, shared multiplier, filter state and result register.
module rlpg_dp
    import rlpg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rlpg_cmd_t                   cmd,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]           cfg_data,
    input  logic signed [SAMPLE_W-1:0]  volt_ab,
    input  logic signed [SAMPLE_W-1:0]  volt_bc,
    input  logic signed [SAMPLE_W-1:0]  volt_ca,
    input  logic signed [SAMPLE_W-1:0]  volt_dc_link,
    output logic                        power_good,
    output logic signed [SAMPLE_W-1:0]  filtered_level
);

    logic signed [COEF_W-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [THR_W-1:0]           thr_reg;
    logic signed [STATE_W-1:0]  d1_reg, d1_next, d2_reg, d2_next;

    logic [MAG_W-1:0]           x_reg, x_next;
    logic signed [SAMPLE_W-1:0] dc_reg;
    logic signed [STATE_W-1:0]  y_reg, y_next, t1_reg, t1_next, t2_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [STATE_W-1:0]  fb_reg, fb_next;
    logic                       pg_reg, pg_next;
    logic signed [SAMPLE_W-1:0] level_reg, level_next;

    logic signed [COEF_W-1:0]   mul_coef;
    logic signed [OPND_W-1:0]   mul_opnd;
    logic [MAG_W-1:0]           mag_ab, mag_bc, mag_ca, mag_max;
    logic signed [ACC_W-FRAC_W-1:0] fb_wide;
    logic signed [STATE_W-1:0]  y_round;
    logic signed [STATE_W-FRAC_W-1:0] level_wide;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg  <= B0_RESET;
            b1_reg  <= B1_RESET;
            b2_reg  <= B2_RESET;
            a1_reg  <= A1_RESET;
            a2_reg  <= A2_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_B0:  b0_reg  <= cfg_data;
                REG_B1:  b1_reg  <= cfg_data;
                REG_B2:  b2_reg  <= cfg_data;
                REG_A1:  a1_reg  <= cfg_data;
                REG_A2:  a2_reg  <= cfg_data;
                REG_THR: thr_reg <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else
        begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
        end
    end

    // Largest rectified line voltage of the incoming beat.
    always_comb
    begin
        mag_ab  = abs_sat(volt_ab);
        mag_bc  = abs_sat(volt_bc);
        mag_ca  = abs_sat(volt_ca);
        mag_max = (mag_bc > mag_ab) ? mag_bc : mag_ab;
        x_next  = (mag_ca > mag_max) ? mag_ca : mag_max;
    end

    // Shared 43 x 33 signed multiplier.
    always_comb
    begin
        unique case (cmd.coef_sel)
            COEF_B0: mul_coef = b0_reg;
            COEF_B1: mul_coef = b1_reg;
            COEF_B2: mul_coef = b2_reg;
            COEF_A1: mul_coef = a1_reg;
            COEF_A2: mul_coef = a2_reg;
            default: mul_coef = b0_reg;
        endcase
        unique case (cmd.opnd_sel)
            OPND_X:    mul_opnd = $signed({{(OPND_W-MAG_W){1'b0}}, x_reg});
            OPND_Y_LO: mul_opnd = $signed({1'b0, y_reg[31:0]});
            OPND_Y_HI: mul_opnd = $signed({y_reg[STATE_W-1], y_reg[STATE_W-1:32]});
            default:   mul_opnd = $signed({{(OPND_W-MAG_W){1'b0}}, x_reg});
        endcase
        prod_next = mul_coef * mul_opnd;
    end

    always_comb
    begin
        y_next  = sat65((STATE_W+1)'(prod_reg) + (STATE_W+1)'(d1_reg));
        t1_next = sat65((STATE_W+1)'(prod_reg) + (STATE_W+1)'(d2_reg));

        acc_next = acc_reg;
        if (cmd.acc_load)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else if (cmd.acc_add)
        begin
            acc_next = acc_reg + (ACC_W'(prod_reg) <<< 32);
        end

        // Floor of the exact product by 2^40, saturated to 64 bits.
        fb_wide = acc_reg[ACC_W-1:FRAC_W];
        if (fb_wide[ACC_W-FRAC_W-1:STATE_W-1] != {(ACC_W-FRAC_W-STATE_W+1){fb_wide[STATE_W-1]}})
        begin
            fb_next = fb_wide[ACC_W-FRAC_W-1] ? S64_MIN : S64_MAX;
        end
        else
        begin
            fb_next = fb_wide[STATE_W-1:0];
        end

        d1_next = cmd.upd_d1 ? sat65((STATE_W+1)'(t1_reg) - (STATE_W+1)'(fb_reg)) : d1_reg;
        d2_next = cmd.upd_d2 ? sat65((STATE_W+1)'(t2_reg) - (STATE_W+1)'(fb_reg)) : d2_reg;

        // Round half up, then clamp to the 16-bit output range.
        y_round    = sat65((STATE_W+1)'(y_reg) + (STATE_W+1)'(64'sd1 <<< (FRAC_W-1)));
        level_wide = y_round[STATE_W-1:FRAC_W];
        if (level_wide > (STATE_W-FRAC_W)'(32'sd32767))
        begin
            level_next = 16'sh7fff;
        end
        else if (level_wide < -(STATE_W-FRAC_W)'(32'sd32768))
        begin
            level_next = 16'sh8000;
        end
        else
        begin
            level_next = level_wide[SAMPLE_W-1:0];
        end
        pg_next = (level_next > $signed({1'b0, thr_reg})) && (dc_reg >= level_next);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.load_in)
        begin
            x_reg  <= x_next;
            dc_reg <= volt_dc_link;
        end
        if (cmd.load_y)
        begin
            y_reg <= y_next;
        end
        if (cmd.load_t1)
        begin
            t1_reg <= t1_next;
        end
        if (cmd.load_t2)
        begin
            t2_reg <= prod_reg[STATE_W-1:0];
        end
        if (cmd.fb_load)
        begin
            fb_reg <= fb_next;
        end
        if (cmd.res_load)
        begin
            pg_reg    <= pg_next;
            level_reg <= level_next;
        end
    end

    assign power_good     = pg_reg;
    assign filtered_level = level_reg;

endmodule

FILE: rtl/core/rectified_line_power_good_detector_top.sv
// One sample beat is worked on at a time: the single shared 43 x 33 multiplier
// runs the seven partial products of the biquad in turn.
// Reset: rst_n clears the sequencer, the result valid flag and both filter delays,
// and loads the default coefficients and threshold.
module rectified_line_power_good_detector_top
    import rlpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rlpg_in_if.sink              samples,
    rlpg_out_if.source           result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    // The sequencer accepts a sample beat only when idle, so one beat is in
    // flight at a time. A finished result sits in the output register while the
    // next beat is already being worked on; only the final load waits for it.
    rlpg_cmd_t cmd;

    rlpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // The datapath holds the coefficients, the multiplier, the 107-bit feedback
    // accumulator that builds a*y from two partial products, and the state.
    rlpg_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .volt_ab        (samples.volt_ab),
        .volt_bc        (samples.volt_bc),
        .volt_ca        (samples.volt_ca),
        .volt_dc_link   (samples.volt_dc_link),
        .power_good     (result.power_good),
        .filtered_level (result.filtered_level)
    );

endmodule

FILE: rtl/core/rlpg_checker.sv
// Port-level checks of the power-good detector and their binding to the top level.
`include "rectified_line_power_good_detector_top_defines.svh"

module rlpg_checker
    import rlpg_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       power_good,
    input logic signed [SAMPLE_W-1:0] filtered_level
);

    // A waiting result beat holds.
`RLPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_level) && $stable(power_good))
    // Power good needs a strictly positive level.
`RLPG_ASSERT_NOW(a_pg_level, out_valid && power_good, !filtered_level[SAMPLE_W-1] && filtered_level != '0)
    // One beat at a time: no sample is taken right after another.
`RLPG_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // A result is only loaded at the end of the filter pass, so no result appears right after a sample.
`RLPG_ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind rectified_line_power_good_detector_top rlpg_checker u_rlpg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (samples.valid),
    .in_ready       (samples.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .power_good     (result.power_good),
    .filtered_level (result.filtered_level)
);
